/* rtl/aesctr_pkg.sv */
package aesctr_pkg;

   localparam int KeyRegCount = 7;
   localparam int RoundKeyWordsDefault = 60;

   localparam logic MODE_CTR   = 1'b0;
   localparam logic MODE_BLOCK = 1'b1;

   typedef enum logic [2:0] {
      CSR_KEY_LENGTH   = 3'd0,
      CSR_KEY_WORD_A   = 3'd1,
      CSR_KEY_WORD_B   = 3'd2,
      CSR_KEY_WORD_C   = 3'd3,
      CSR_KEY_WORD_D   = 3'd4,
      CSR_CTR_FRONT    = 3'd5,
      CSR_CTR_BACK     = 3'd6,
      CSR_UNUSED       = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   localparam logic [2047:0] SboxTable = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [10:0] base;
      base = 11'(11'd2047 - {x, 3'b000});
      return SboxTable[base -: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      logic [31:0] r;
      for (int b = 0; b < 4; b++) begin
         r[8*b +: 8] = sbox(w[8*b +: 8]);
      end
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [127:0] sb;
      logic [127:0] sr;
      logic [127:0] mc;
      logic [7:0] a0, a1, a2, a3;
      for (int k = 0; k < 16; k++) begin
         sb[8*k +: 8] = sbox(s[8*k +: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sr[8*(4*c+i) +: 8] = sb[8*(4*((c+i)%4)+i) +: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sr[8*(4*c)   +: 8];
         a1 = sr[8*(4*c+1) +: 8];
         a2 = sr[8*(4*c+2) +: 8];
         a3 = sr[8*(4*c+3) +: 8];
         mc[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         mc[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         mc[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         mc[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return last ? sr : mc;
   endfunction

   function automatic logic [127:0] byte_swap(input logic [127:0] v);
      logic [127:0] r;
      for (int k = 0; k < 16; k++) begin
         r[8*k +: 8] = v[8*(15-k) +: 8];
      end
      return r;
   endfunction

endpackage

/* rtl/aes_ctr_block_cipher.sv */
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | mode, start_req, data_front/back, byte_count
// rsp     | out       | rsp_valid/stall   | result_front/back, result_count
// csr     | in        | csr_valid/ready   | csr_index, csr_data
// A transaction loads the state on acceptance, then runs 10 or 14 rounds on the shared round unit.
// A key register write runs the key schedule, 44 or 60 words at one word per cycle;
// csr_ready and req are held off meanwhile.
// A finished result waits in the output register; the last round holds while it is stalled.
// Reset is synchronous and clears control and counter state; the round keys are undefined.
module aes_ctr_block_cipher
   import aesctr_pkg::*;
#(
   parameter int ROUND_KEY_WORDS = RoundKeyWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_start_req,
   input  logic [63:0] req_data_front,
   input  logic [63:0] req_data_back,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_front,
   output logic [63:0] rsp_result_back,
   output logic [4:0]  rsp_result_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int RkRows = ROUND_KEY_WORDS / 4;
   localparam int RkAw = $clog2(RkRows);

   logic          key_len_ff;
   logic [255:0]  key_ff;
   logic [127:0]  ictr_ff;
   logic [127:0]  ctr_ff, ctr_in;
   logic [127:0]  rk_mem [RkRows];

   logic          exp_busy_ff, exp_busy_in;
   logic [5:0]    exp_idx_ff, exp_idx_in;
   logic [31:0]   win_ff [8];
   logic [7:0]    rc_ff, rc_in;
   logic          exp_nk8_ff;
   logic [31:0]   exp_word;
   logic [31:0]   exp_t;

   state_type     state_ff, state_in;
   logic [3:0]    round_ff, round_in;
   logic [127:0]  st_ff, st_in;
   logic          mode_ff;
   logic [127:0]  data_ff;
   logic [4:0]    n_ff;
   logic          nr14_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [127:0]  res_ff, res_in;
   logic [4:0]    cnt_ff, cnt_in;

   logic          req_acc, csr_acc, csr_key_write, out_free, last_round;
   logic [127:0]  rk_row, ctr_cur, st_next, ks_masked;
   logic [4:0]    n_req;
   csr_index_type csr_sel;

   assign csr_sel   = csr_index_type'(csr_index);
   assign csr_ready = !exp_busy_ff;
   assign csr_acc   = csr_valid && csr_ready;
   assign csr_key_write = (csr_sel == CSR_KEY_LENGTH) || (csr_sel == CSR_KEY_WORD_A) ||
                          (csr_sel == CSR_KEY_WORD_B) || (csr_sel == CSR_KEY_WORD_C) ||
                          (csr_sel == CSR_KEY_WORD_D);
   assign req_stall = (state_ff != ST_IDLE) || exp_busy_ff;
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_round = round_ff == (nr14_ff ? 4'd14 : 4'd10);

   always_comb begin
      if (32'(round_ff) < RkRows) begin
         rk_row = rk_mem[round_ff[RkAw-1:0]];
      end else begin
         rk_row = '0;
      end
   end

   // key schedule word
   always_comb begin
      exp_t = win_ff[7];
      rc_in = rc_ff;
      if (exp_nk8_ff ? (exp_idx_ff[2:0] == 3'd0) : (exp_idx_ff[1:0] == 2'd0)) begin
         exp_t = sub_word({exp_t[7:0], exp_t[31:8]}) ^ {24'd0, rc_ff};
         rc_in = xtime(rc_ff);
      end else if (exp_nk8_ff && exp_idx_ff[2:0] == 3'd4) begin
         exp_t = sub_word(exp_t);
      end
      if (exp_idx_ff < (exp_nk8_ff ? 6'd8 : 6'd4)) begin
         exp_word = key_ff[32*exp_idx_ff[2:0] +: 32];
         rc_in    = rc_ff;
      end else begin
         exp_word = (exp_nk8_ff ? win_ff[0] : win_ff[4]) ^ exp_t;
      end
      exp_busy_in = exp_busy_ff;
      exp_idx_in  = exp_idx_ff;
      if (exp_busy_ff) begin
         exp_idx_in = 6'(exp_idx_ff + 6'd1);
         if (exp_idx_ff == (exp_nk8_ff ? 6'd59 : 6'd43)) begin
            exp_busy_in = 1'b0;
         end
      end
      if (csr_acc) begin
         rc_in = 8'h01;
         if (csr_key_write) begin
            exp_busy_in = 1'b1;
            exp_idx_in  = 6'd0;
         end
      end
   end

   always_comb begin
      ctr_cur   = req_start_req ? ictr_ff : ctr_ff;
      n_req     = (req_byte_count > 5'd16) ? 5'd16 : req_byte_count;
      st_next   = aes_round(st_ff, last_round) ^ rk_row;
      for (int k = 0; k < 16; k++) begin
         ks_masked[8*k +: 8] = (5'(k) < n_ff) ? st_next[8*k +: 8] : 8'h00;
      end
      ctr_in       = ctr_ff;
      state_in     = state_ff;
      round_in     = round_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ctr_in = ctr_cur;
               if (req_mode == MODE_CTR && n_req != 5'd0) begin
                  ctr_in = byte_swap(byte_swap(ctr_cur) + 128'd1);
               end
               st_in    = ((req_mode == MODE_BLOCK) ? {req_data_back, req_data_front}
                                                    : ctr_cur) ^ rk_row;
               round_in = 4'd1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!last_round) begin
               st_in    = st_next;
               round_in = 4'(round_ff + 4'd1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               res_in   = (mode_ff == MODE_BLOCK) ? st_next : (data_ff ^ ks_masked);
               cnt_in   = (mode_ff == MODE_BLOCK) ? 5'd16 : n_ff;
               round_in = 4'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
         exp_busy_ff  <= 1'b0;
         exp_idx_ff   <= 6'd0;
         key_len_ff   <= 1'b0;
         key_ff       <= '0;
         ictr_ff      <= '0;
         ctr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         exp_busy_ff  <= exp_busy_in;
         exp_idx_ff   <= exp_idx_in;
         ctr_ff       <= ctr_in;
         if (csr_acc) begin
            unique case (csr_sel)
               CSR_KEY_LENGTH: key_len_ff <= csr_data[0];
               CSR_KEY_WORD_A: key_ff[63:0]    <= csr_data;
               CSR_KEY_WORD_B: key_ff[127:64]  <= csr_data;
               CSR_KEY_WORD_C: key_ff[191:128] <= csr_data;
               CSR_KEY_WORD_D: key_ff[255:192] <= csr_data;
               CSR_CTR_FRONT:  ictr_ff[63:0]   <= csr_data;
               CSR_CTR_BACK:   ictr_ff[127:64] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
      rc_ff  <= rc_in;
      if (csr_acc) begin
         exp_nk8_ff <= (csr_sel == CSR_KEY_LENGTH) ? csr_data[0] : key_len_ff;
      end
      if (req_acc) begin
         mode_ff <= req_mode;
         data_ff <= {req_data_back, req_data_front};
         n_ff    <= n_req;
         nr14_ff <= key_len_ff;
      end
      if (exp_busy_ff) begin
         for (int j = 0; j < 7; j++) begin
            win_ff[j] <= win_ff[j+1];
         end
         win_ff[7] <= exp_word;
         if (32'(exp_idx_ff) < ROUND_KEY_WORDS) begin
            rk_mem[exp_idx_ff[RkAw+1:2]][32*exp_idx_ff[1:0] +: 32] <= exp_word;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_front = res_ff[63:0];
   assign rsp_result_back  = res_ff[127:64];
   assign rsp_result_count = cnt_ff;

   a_exp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      exp_busy_ff |-> (req_stall && !csr_ready))
      else $error("key schedule running while ports open");

   a_run_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> req_stall)
      else $error("input open during rounds");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cnt_ff <= 5'd16))
      else $error("result count out of range");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (round_ff != 4'd0 && round_ff <= 4'd14))
      else $error("round index out of range");

endmodule

/* tb/aes_ctr_checker.sv */
module aes_ctr_checker
   import aesctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_mode,
   input  logic        req_start_req,
   input  logic [63:0] req_data_front,
   input  logic [63:0] req_data_back,
   input  logic [4:0]  req_byte_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_result_front,
   input  logic [63:0] rsp_result_back,
   input  logic [4:0]  rsp_result_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] front;
      logic [63:0] back;
      logic [4:0]  count;
   } cipher_result_type;

   cipher_result_type expected_results[$];
   logic [63:0] key_regs[KeyRegCount];
   logic [31:0] round_keys[60];
   logic [7:0]  sbox_tab[256];
   logic [127:0] run_counter;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return r;
   endfunction

   function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
      return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
   endfunction

   initial begin
      logic [7:0] inv, p, s, t;
      int e;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         p = 8'(x);
         e = 254;
         while (e != 0) begin
            if (e & 1) inv = gf_mul(inv, p);
            p = gf_mul(p, p);
            e = e >> 1;
         end
         s = inv;
         t = inv;
         for (int j = 0; j < 4; j++) begin
            t = {t[6:0], t[7]};
            s ^= t;
         end
         sbox_tab[x] = s ^ 8'h63;
      end
   end

   task automatic expand_schedule();
      logic [31:0] w[60];
      logic [31:0] t;
      logic [7:0] rc;
      int nk, total;
      nk = key_regs[CSR_KEY_LENGTH][0] ? 8 : 4;
      total = key_regs[CSR_KEY_LENGTH][0] ? 60 : 44;
      rc = 8'h01;
      for (int i = 0; i < nk; i++) begin
         w[i] = key_regs[1 + i / 2][32 * (i % 2) +: 32];
      end
      for (int i = nk; i < total; i++) begin
         t = w[i - 1];
         if (i % nk == 0) begin
            t = sub_bytes32({t[7:0], t[31:8]}) ^ {24'h0, rc};
            rc = gf_mul(rc, 8'h02);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_bytes32(t);
         end
         w[i] = w[i - nk] ^ t;
      end
      for (int i = 0; i < total; i++) begin
         round_keys[i] = w[i];
      end
   endtask

   function automatic logic [127:0] cipher_block(input logic [127:0] blk);
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] out;
      int nr;
      nr = key_regs[CSR_KEY_LENGTH][0] ? 14 : 10;
      for (int i = 0; i < 16; i++) s[i] = blk[8 * i +: 8];
      for (int r = 0; r <= nr; r++) begin
         if (r > 0) begin
            for (int c = 0; c < 4; c++) begin
               for (int i = 0; i < 4; i++) begin
                  t[4 * c + i] = sbox_tab[s[4 * ((c + i) % 4) + i]];
               end
            end
            for (int c = 0; c < 4; c++) begin
               a0 = t[4 * c];
               a1 = t[4 * c + 1];
               a2 = t[4 * c + 2];
               a3 = t[4 * c + 3];
               if (r != nr) begin
                  s[4 * c]     = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
                  s[4 * c + 1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
                  s[4 * c + 2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
                  s[4 * c + 3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
               end else begin
                  s[4 * c] = a0;
                  s[4 * c + 1] = a1;
                  s[4 * c + 2] = a2;
                  s[4 * c + 3] = a3;
               end
            end
         end
         for (int c = 0; c < 4; c++) begin
            for (int b = 0; b < 4; b++) begin
               s[4 * c + b] ^= round_keys[4 * r + c][8 * b +: 8];
            end
         end
      end
      for (int i = 0; i < 16; i++) out[8 * i +: 8] = s[i];
      return out;
   endfunction

   task automatic predict_result();
      cipher_result_type res;
      logic [127:0] data, stream;
      int n;
      if (req_start_req) run_counter = {key_regs[CSR_CTR_BACK], key_regs[CSR_CTR_FRONT]};
      data = {req_data_back, req_data_front};
      if (req_mode != MODE_CTR) begin
         data = cipher_block(data);
         n = 16;
      end else begin
         n = (req_byte_count > 16) ? 16 : int'(req_byte_count);
         if (n > 0) begin
            stream = cipher_block(run_counter);
            for (int i = 15; i >= 0; i--) begin
               run_counter[8 * i +: 8] = run_counter[8 * i +: 8] + 8'd1;
               if (run_counter[8 * i +: 8] != 8'd0) break;
            end
            for (int i = 0; i < n; i++) data[8 * i +: 8] ^= stream[8 * i +: 8];
         end
      end
      res.front = data[63:0];
      res.back = data[127:64];
      res.count = 5'(n);
      expected_results.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic compare_result();
      cipher_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected transaction", rsp_result_front, 64'h0);
      end else begin
         want = expected_results.pop_front();
         if (rsp_result_front !== want.front)
            report_mismatch("result_front", rsp_result_front, want.front);
         if (rsp_result_back !== want.back)
            report_mismatch("result_back", rsp_result_back, want.back);
         if (rsp_result_count !== want.count)
            report_mismatch("result_count", 64'(rsp_result_count), 64'(want.count));
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      run_counter = '0;
      for (int i = 0; i < KeyRegCount; i++) key_regs[i] = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         run_counter = '0;
         for (int i = 0; i < KeyRegCount; i++) key_regs[i] = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < KeyRegCount) begin
            key_regs[csr_index] = (csr_index == CSR_KEY_LENGTH) ? {63'h0, csr_data[0]}
                                                                : csr_data;
            if (csr_index <= CSR_KEY_WORD_D) expand_schedule();
         end
         if (req_valid && !req_stall) predict_result();
         if (rsp_valid && !rsp_stall) compare_result();
      end
      pending = expected_results.size();
   end

endmodule

/* tb/testbench.sv */
module testbench;
   import aesctr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [63:0] ONES = '1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic        req_start_req;
   logic [63:0] req_data_front;
   logic [63:0] req_data_back;
   logic [4:0]  req_byte_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result_front;
   logic [63:0] rsp_result_back;
   logic [4:0]  rsp_result_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;
   int          fail_count;
   int          pending;
   bit          hold_rsp;
   int          burst_left;

   aes_ctr_block_cipher u_dut (.*);

   aes_ctr_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int pattern, span;
      span = 0;
      pattern = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            if (span == 0) begin
               pattern = $urandom_range(0, 3);
               span = $urandom_range(16, 120);
            end
            span--;
            case (pattern)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic klen, input logic [63:0] ka, kb, kc, kd,
                                input logic [63:0] cf, cb);
      csr_write(CSR_KEY_LENGTH, {63'h0, klen});
      csr_write(CSR_KEY_WORD_A, ka);
      csr_write(CSR_KEY_WORD_B, kb);
      csr_write(CSR_KEY_WORD_C, kc);
      csr_write(CSR_KEY_WORD_D, kd);
      csr_write(CSR_CTR_FRONT, cf);
      csr_write(CSR_CTR_BACK, cb);
   endtask

   task automatic send_block(input logic mode, input logic start, input logic [63:0] front,
                             input logic [63:0] back, input logic [4:0] count);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_mode <= mode;
      req_start_req <= start;
      req_data_front <= front;
      req_data_back <= back;
      req_byte_count <= count;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(input int items, input bit long_hold, input bit mid_pause);
      logic mode;
      logic [4:0] count;
      int r;
      if (long_hold) hold_rsp = 1'b1;
      for (int i = 0; i < items; i++) begin
         if (mid_pause && i == items / 2) begin
            @(negedge clock);
            req_valid <= 1'b0;
            burst_left = 0;
            while (pending != 0) @(negedge clock);
         end
         mode = ($urandom_range(0, 9) < 3) ? MODE_BLOCK : MODE_CTR;
         r = $urandom_range(0, 19);
         if (r == 0) count = 5'd0;
         else if (r == 1) count = 5'($urandom_range(17, 31));
         else if (r < 8) count = 5'($urandom_range(1, 15));
         else count = 5'd16;
         send_block(mode, (i == 0) || ($urandom_range(0, 19) == 0),
                    pick_word(), pick_word(), count);
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_CTR;
      req_start_req = 1'b0;
      req_data_front = '0;
      req_data_back = '0;
      req_byte_count = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_LENGTH;
      csr_data = '0;
      hold_rsp = 1'b0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_settings(1'b0, pick_word(), pick_word(), pick_word(), pick_word(), ONES, ONES);
      send_block(MODE_CTR, 1'b1, '0, '0, 5'd16);
      send_block(MODE_CTR, 1'b0, ONES, ONES, 5'd16);
      send_block(MODE_CTR, 1'b0, ONES, ONES, 5'd1);
      send_block(MODE_CTR, 1'b0, ONES, '0, 5'd15);
      send_block(MODE_CTR, 1'b0, ONES, ONES, 5'd0);
      send_block(MODE_CTR, 1'b0, '0, ONES, 5'd17);
      send_block(MODE_CTR, 1'b0, ONES, ONES, 5'd31);
      send_block(MODE_BLOCK, 1'b0, '0, '0, 5'd0);
      send_block(MODE_BLOCK, 1'b1, ONES, ONES, 5'd31);
      send_block(MODE_CTR, 1'b0, '0, '0, 5'd8);
      drain();
      load_settings(1'b1, ONES, ONES, ONES, ONES, '0, '0);
      send_block(MODE_CTR, 1'b1, ONES, ONES, 5'd16);
      send_block(MODE_BLOCK, 1'b0, '0, '0, 5'd16);
      send_block(MODE_BLOCK, 1'b0, ONES, ONES, 5'd16);
      send_block(MODE_CTR, 1'b0, ONES, ONES, 5'd0);
      send_block(MODE_CTR, 1'b0, '0, '0, 5'd31);
      drain();
      load_settings(1'b0, '0, '0, '0, '0, '0, 64'h00ff_ffff_ffff_ffff);
      send_block(MODE_BLOCK, 1'b0, '0, '0, 5'd16);
      send_block(MODE_CTR, 1'b1, '0, '0, 5'd16);
      send_block(MODE_CTR, 1'b0, ONES, ONES, 5'd16);
      drain();

      for (int p = 0; p < 6; p++) begin
         load_settings(1'(p), pick_word(), pick_word(), pick_word(), pick_word(),
                       pick_word(), pick_word());
         random_phase(222, p == 2, p == 3);
      end

      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/aesctr_pkg.sv
rtl/aes_ctr_block_cipher.sv
tb/aes_ctr_checker.sv
tb/testbench.sv
